@@ rtl/byte_lifo_stack_top_assert.svh @@
// ----------------------------------------------------------------------------
// byte lifo stack assertion macros
// shared assertion forms for the stack checker
// ----------------------------------------------------------------------------
`ifndef BYTE_LIFO_STACK_TOP_ASSERT_SVH
`define BYTE_LIFO_STACK_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BLS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bls_pkg.sv @@
// ----------------------------------------------------------------------------
// bls_pkg
// types and constants shared by the byte lifo stack
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 8;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 5;
    localparam int POS_W       = 5;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2,
        CMD_CHANGE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_EMPTY  = 2'd2,
        STATUS_BADPOS = 2'd3
    } status_t;

    // request from the control to the storage
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // result of one word, data still to come from the storage
    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] count;
        logic             use_mem;
    } res_t;

endpackage

@@ rtl/byte_lifo_stack_top.sv @@
// ----------------------------------------------------------------------------
// byte_lifo_stack_top
// byte-wide lifo stack with push, pop, peek and change by position
// ----------------------------------------------------------------------------
//  channel   ports        direction   carries
//  s_        valid/ready  in          command, item, position
//  m_        valid/ready  out         data, status, fill_count, full/empty flag
//
//  one word accepted per cycle while s_ready is high; its result passes through
//  the result stage, which waits on the registered read port of the storage, and the output
//  register; count is updated at acceptance so back-to-back words see it
//  synchronous active-low reset empties the stack, storage is not cleared
//  a stalled output holds the result stage, and s_ready drops once both are full
// ----------------------------------------------------------------------------
module byte_lifo_stack_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bls_pkg::CMD_W-1:0]          s_command,
    input  logic [bls_pkg::DATA_W-1:0]         s_item,
    input  logic [bls_pkg::POS_W-1:0]          s_position,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [bls_pkg::DATA_W-1:0]         m_data,
    output logic [bls_pkg::STATUS_W-1:0]       m_status,
    output logic [bls_pkg::CNT_W-1:0]          m_fill_count,
    output logic                               m_full_flag,
    output logic                               m_empty_flag
);

    localparam logic [bls_pkg::CNT_W-1:0] FULL_CNT = bls_pkg::CNT_W'(bls_pkg::STACK_DEPTH);

    bls_pkg::mem_req_t          req;
    bls_pkg::res_t              res;
    logic [bls_pkg::DATA_W-1:0] rd_data;

    logic                          accept;
    logic                          out_free;
    logic                          p_valid_reg;
    bls_pkg::res_t                 p_res_reg;
    logic                          m_valid_reg;
    logic [bls_pkg::DATA_W-1:0]    m_data_reg;
    logic [bls_pkg::STATUS_W-1:0]  m_status_reg;
    logic [bls_pkg::CNT_W-1:0]     m_fill_count_reg;
    logic                          m_full_reg;
    logic                          m_empty_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !p_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    bls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .command  (s_command),
        .item     (s_item),
        .position (s_position),
        .req      (req),
        .res      (res)
    );

    bls_mem u_mem (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    // result stage waits for the registered storage read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (accept) begin
            p_valid_reg <= 1'b1;
        end else if (out_free) begin
            p_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_res_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && p_valid_reg) begin
            m_data_reg       <= p_res_reg.use_mem ? rd_data : '0;
            m_status_reg     <= p_res_reg.status;
            m_fill_count_reg <= p_res_reg.count;
            m_full_reg       <= (p_res_reg.count == FULL_CNT);
            m_empty_reg      <= (p_res_reg.count == '0);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;
    assign m_status     = m_status_reg;
    assign m_fill_count = m_fill_count_reg;
    assign m_full_flag  = m_full_reg;
    assign m_empty_flag = m_empty_reg;

endmodule

@@ rtl/bls_mem.sv @@
// ----------------------------------------------------------------------------
// bls_mem
// stack storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module bls_mem (
    input  logic                             aclk,
    input  bls_pkg::mem_req_t                req,
    output logic [bls_pkg::DATA_W-1:0]       rd_data
);

    logic [bls_pkg::DATA_W-1:0] mem_array [bls_pkg::STACK_DEPTH];
    logic [bls_pkg::DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_array[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_data_reg <= mem_array[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/bls_ctrl.sv @@
// ----------------------------------------------------------------------------
// bls_ctrl
// command decode, fill count and storage access
// ----------------------------------------------------------------------------
module bls_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic [bls_pkg::CMD_W-1:0]       command,
    input  logic [bls_pkg::DATA_W-1:0]      item,
    input  logic [bls_pkg::POS_W-1:0]       position,
    output bls_pkg::mem_req_t               req,
    output bls_pkg::res_t                   res
);

    localparam logic [bls_pkg::CNT_W-1:0] FULL_CNT = bls_pkg::CNT_W'(bls_pkg::STACK_DEPTH);
    localparam logic [bls_pkg::CNT_W-1:0] CNT_ONE  = bls_pkg::CNT_W'(1);
    localparam logic [bls_pkg::POS_W-1:0] POS_ONE  = bls_pkg::POS_W'(1);

    logic [bls_pkg::CNT_W-1:0] count_reg;
    logic [bls_pkg::CNT_W-1:0] count_next;
    logic [bls_pkg::CNT_W-1:0] count_dec;
    logic [bls_pkg::POS_W-1:0] pos_dec;
    logic                      is_full;
    logic                      stack_empty;
    logic                      pos_ok;

    assign is_full     = (count_reg == FULL_CNT);
    assign stack_empty = (count_reg == '0);
    assign count_dec   = count_reg - CNT_ONE;
    assign pos_dec     = position - POS_ONE;
    assign pos_ok      = (position != '0) && (bls_pkg::CNT_W'(position) <= count_reg);

    always_comb begin
        req         = '0;
        req.wdata   = item;
        res.status  = bls_pkg::STATUS_OK;
        res.use_mem = 1'b0;
        count_next  = count_reg;
        case (bls_pkg::cmd_t'(command))
            bls_pkg::CMD_PUSH: begin
                if (is_full) begin
                    res.status = bls_pkg::STATUS_FULL;
                end else begin
                    req.we     = accept;
                    req.waddr  = count_reg[bls_pkg::ADDR_W-1:0];
                    count_next = count_reg + CNT_ONE;
                end
            end
            bls_pkg::CMD_POP, bls_pkg::CMD_PEEK: begin
                if (stack_empty) begin
                    res.status = bls_pkg::STATUS_EMPTY;
                end else begin
                    req.re      = accept;
                    req.raddr   = count_dec[bls_pkg::ADDR_W-1:0];
                    res.use_mem = 1'b1;
                    if (bls_pkg::cmd_t'(command) == bls_pkg::CMD_POP) begin
                        count_next = count_dec;
                    end
                end
            end
            bls_pkg::CMD_CHANGE: begin
                if (pos_ok) begin
                    req.we    = accept;
                    req.waddr = pos_dec[bls_pkg::ADDR_W-1:0];
                end else begin
                    res.status = bls_pkg::STATUS_BADPOS;
                end
            end
            default: begin
                res.status = bls_pkg::STATUS_BADPOS;
            end
        endcase
        res.count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/bls_checker.sv @@
// ----------------------------------------------------------------------------
// bls_checker
// port-level checks on the stack results
// ----------------------------------------------------------------------------
`include "byte_lifo_stack_top_assert.svh"

module bls_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [bls_pkg::DATA_W-1:0]         m_data,
    input  logic [bls_pkg::STATUS_W-1:0]       m_status,
    input  logic [bls_pkg::CNT_W-1:0]          m_fill_count,
    input  logic                               m_full_flag,
    input  logic                               m_empty_flag
);

    localparam logic [bls_pkg::CNT_W-1:0] FULL_CNT = bls_pkg::CNT_W'(bls_pkg::STACK_DEPTH);

    `BLS_ASSERT_NOW(a_count_range, m_valid, m_fill_count <= FULL_CNT, "fill count above depth")
    `BLS_ASSERT_NOW(a_full_flag, m_valid, m_full_flag == (m_fill_count == FULL_CNT), "full flag mismatch")
    `BLS_ASSERT_NOW(a_empty_flag, m_valid, m_empty_flag == (m_fill_count == '0), "empty flag mismatch")
    `BLS_ASSERT_NOW(a_data_ok, m_valid && (m_data != '0), m_status == bls_pkg::STATUS_OK, "data on failed word")
    `BLS_ASSERT_NEXT(a_valid_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped")

endmodule

bind byte_lifo_stack_top bls_checker u_bls_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_data       (m_data),
    .m_status     (m_status),
    .m_fill_count (m_fill_count),
    .m_full_flag  (m_full_flag),
    .m_empty_flag (m_empty_flag)
);

@@ tb/sv/byte_lifo_stack_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_lifo_stack_top_test
// drives push, pop, peek and change words into the stack with random gaps on
// both sides and compares every result against a predicted stack image
// ----------------------------------------------------------------------------
module byte_lifo_stack_top_test;
    import bls_pkg::*;

    localparam int RANDOM_WORDS   = 1050;
    localparam int HOLD_OFF_LEN   = 90;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // predicted stack image and the results still owed by the block
    class stack_scoreboard;
        typedef struct {
            logic [DATA_W-1:0] data;
            status_t           status;
            logic [CNT_W-1:0]  fill;
            logic              full;
            logic              empty;
        } stack_result_t;

        logic [DATA_W-1:0] entries [STACK_DEPTH];
        int unsigned       held;
        stack_result_t     owed_results [$];
        int unsigned       mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function int unsigned fill_level();
            return held;
        endfunction

        function int unsigned owed_count();
            return owed_results.size();
        endfunction

        task report(string msg);
            $display("%0t: mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // apply one accepted word to the image and queue its result
        function void note_word(cmd_t cmd, logic [DATA_W-1:0] item,
                                logic [POS_W-1:0] pos);
            stack_result_t r;
            r.data   = '0;
            r.status = STATUS_OK;
            case (cmd)
                CMD_PUSH: begin
                    if (held < STACK_DEPTH) begin
                        entries[held] = item;
                        held++;
                    end else begin
                        r.status = STATUS_FULL;
                    end
                end
                CMD_POP, CMD_PEEK: begin
                    if (held == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        r.data = entries[held-1];
                        if (cmd == CMD_POP)
                            held--;
                    end
                end
                default: begin
                    if (pos >= 1 && pos <= held)
                        entries[pos-1] = item;
                    else
                        r.status = STATUS_BADPOS;
                end
            endcase
            r.fill  = held[CNT_W-1:0];
            r.full  = (held == STACK_DEPTH);
            r.empty = (held == 0);
            owed_results.push_back(r);
        endfunction

        task check_word(logic [DATA_W-1:0] data, logic [STATUS_W-1:0] status,
                        logic [CNT_W-1:0] fill, logic full, logic empty);
            stack_result_t e;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected word: data %h status %0d fill %0d",
                                 data, status, fill));
                return;
            end
            e = owed_results.pop_front();
            if (data !== e.data)
                report($sformatf("data %h, want %h", data, e.data));
            if (status !== e.status)
                report($sformatf("status %0d, want %s", status, e.status.name()));
            if (fill !== e.fill)
                report($sformatf("fill_count %0d, want %0d", fill, e.fill));
            if (full !== e.full)
                report($sformatf("full_flag %b, want %b", full, e.full));
            if (empty !== e.empty)
                report($sformatf("empty_flag %b, want %b", empty, e.empty));
        endtask
    endclass

    logic                aclk;
    logic                aresetn      = 1'b0;
    logic                s_valid      = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_command    = '0;
    logic [DATA_W-1:0]   s_item       = '0;
    logic [POS_W-1:0]    s_position   = '0;
    logic                m_valid;
    logic                m_ready      = 1'b0;
    logic [DATA_W-1:0]   m_data;
    logic [STATUS_W-1:0] m_status;
    logic [CNT_W-1:0]    m_fill_count;
    logic                m_full_flag;
    logic                m_empty_flag;

    logic                hold_req     = 1'b0;
    logic                quiet_tail   = 1'b0;

    stack_scoreboard     sb = new();

    byte_lifo_stack_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_item       (s_item),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .m_status     (m_status),
        .m_fill_count (m_fill_count),
        .m_full_flag  (m_full_flag),
        .m_empty_flag (m_empty_flag)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // offer one word and hold it until accepted
    task automatic send_word(cmd_t cmd, logic [DATA_W-1:0] item,
                             logic [POS_W-1:0] pos);
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_item     <= item;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(cmd, item, pos);
    endtask

    task automatic idle_gap(int unsigned cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (sb.owed_count() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    task automatic run_directed();
        send_word(CMD_PEEK, 8'h5a, 5'd0);
        send_word(CMD_POP, 8'ha5, 5'd0);
        send_word(CMD_CHANGE, 8'h11, 5'd0);
        send_word(CMD_CHANGE, 8'h22, 5'd1);
        send_word(CMD_PUSH, 8'h00, 5'd31);
        send_word(CMD_PUSH, 8'hff, 5'd0);
        for (int i = 2; i < STACK_DEPTH; i++)
            send_word(CMD_PUSH, DATA_W'($urandom_range(0, 255)), 5'd0);
        send_word(CMD_PUSH, 8'h3c, 5'd0);
        send_word(CMD_CHANGE, 8'hc3, 5'(STACK_DEPTH));
        send_word(CMD_CHANGE, 8'h81, 5'd1);
        send_word(CMD_CHANGE, 8'h7e, 5'd0);
        send_word(CMD_PEEK, 8'hff, 5'd16);
        send_word(CMD_POP, 8'h00, 5'd0);
    endtask

    task automatic run_random(int unsigned total);
        int unsigned sent;
        int unsigned phase_left;
        int unsigned mode;
        int unsigned roll;
        int unsigned quiet_start;
        bit          gapless;
        cmd_t        cmd;
        logic [DATA_W-1:0] item;
        logic [POS_W-1:0]  pos;
        sent        = 0;
        phase_left  = 0;
        mode        = 0;
        gapless     = 1'b0;
        quiet_start = total * 6 / 7;
        while (sent < total) begin
            // phases lean toward filling, draining, balance or pure noise
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 60);
                mode       = $urandom_range(0, 3);
                gapless    = ($urandom_range(0, 3) == 0);
            end
            roll = $urandom_range(0, 99);
            if (mode == 3)
                cmd = cmd_t'($urandom_range(0, 3));
            else if (roll < (mode == 0 ? 55 : mode == 1 ? 20 : 35))
                cmd = CMD_PUSH;
            else if (roll < (mode == 0 ? 68 : 68))
                cmd = CMD_POP;
            else if (roll < 82)
                cmd = CMD_PEEK;
            else
                cmd = CMD_CHANGE;
            item = DATA_W'($urandom_range(0, 255));
            if (cmd == CMD_CHANGE && sb.fill_level() > 0 && $urandom_range(0, 3) != 0)
                pos = POS_W'($urandom_range(1, sb.fill_level()));
            else
                pos = POS_W'($urandom_range(0, STACK_DEPTH));
            send_word(cmd, item, pos);
            sent++;
            phase_left--;
            if (sent == 300)
                hold_req <= 1'b1;
            if (sent == quiet_start)
                quiet_tail <= 1'b1;
            if (sent == 600)
                wait_all_results();
            else if (sent < quiet_start && !gapless && $urandom_range(0, 5) == 0)
                idle_gap($urandom_range(1, 17));
        end
    endtask

    // result side: random stall bursts, one long hold-off, quiet at the end
    int unsigned stall_left = 0;
    int unsigned calm_left  = 0;
    bit          hold_done  = 1'b0;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_word(m_data, m_status, m_fill_count, m_full_flag, m_empty_flag);
        if (hold_req && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = HOLD_OFF_LEN;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (calm_left > 0) begin
            calm_left--;
            m_ready <= 1'b1;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 16);
            calm_left  = ($urandom_range(0, 3) == 0) ? 150 : $urandom_range(0, 60);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ends the run when nothing moves on either side for too long
    int unsigned stuck_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("byte_lifo_stack_top test failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        wait_all_results();
        run_random(RANDOM_WORDS);
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.owed_count() != 0)
            sb.report($sformatf("%0d results never arrived", sb.owed_count()));
        if (sb.mismatches == 0) begin
            $display("byte_lifo_stack_top test passed");
        end else begin
            $display("byte_lifo_stack_top test failed");
        end
        $finish;
    end

endmodule
